### design/integer_to_radix_text_padded_macros.svh
// Assertion macros shared by the formatter modules
`ifndef INTEGER_TO_RADIX_TEXT_PADDED_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_PADDED_MACROS_SVH

// Same-cycle implication, checked on every rising clk outside reset
`define ITRTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk outside reset
`define ITRTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/itrtp_pkg.sv
// Shared types, constants and the digit character function of the formatter
`timescale 1ns / 1ps

package itrtp_pkg;

    localparam int SLICE_BITS = 8;
    localparam int MAX_CHARS  = 64;
    localparam int CNT_W      = 8;
    localparam int RADIX_W    = 5;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_COUNT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic calc;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic slice_last;
        logic more_digits;
        logic emit_last;
    } dp_sts_t;

    function automatic logic [7:0] digit_char(input logic [3:0] dig, input logic upper);
        logic [7:0] ch;
        if (dig < 4'd10)
        begin
            ch = CH_ZERO + {4'd0, dig};
        end
        else if (upper)
        begin
            ch = 8'h41 + {4'd0, dig - 4'd10};
        end
        else
        begin
            ch = 8'h61 + {4'd0, dig - 4'd10};
        end
        return ch;
    endfunction

endpackage

### design/itrtp_ctrl.sv
// Sequencing state machine of the formatter
`timescale 1ns / 1ps
`include "integer_to_radix_text_padded_macros.svh"

module itrtp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  itrtp_pkg::dp_sts_t sts,
    output itrtp_pkg::dp_cmd_t cmd
);

    itrtp_pkg::state_t state_reg;
    itrtp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itrtp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            itrtp_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = itrtp_pkg::ST_DIVIDE;
                end
            end
            itrtp_pkg::ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (sts.slice_last)
                begin
                    state_next = itrtp_pkg::ST_CHECK;
                end
            end
            itrtp_pkg::ST_CHECK:
            begin
                state_next = sts.more_digits ? itrtp_pkg::ST_DIVIDE : itrtp_pkg::ST_COUNT;
            end
            itrtp_pkg::ST_COUNT:
            begin
                cmd.calc   = 1'b1;
                state_next = itrtp_pkg::ST_EMIT;
            end
            itrtp_pkg::ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (sts.emit_last)
                begin
                    state_next = itrtp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itrtp_pkg::ST_IDLE;
            end
        endcase
    end

    `ITRTP_ASSERT_NEXT(a_take_busy, start && !busy, busy, "busy not raised after start")
    `ITRTP_ASSERT_NOW(a_check_order, state_reg == itrtp_pkg::ST_CHECK, $past(state_reg) == itrtp_pkg::ST_DIVIDE, "digit check without a finished division")

endmodule

### design/itrtp_dp.sv
// Datapath: sliced radix divider, digit stack, field counts and character output
`timescale 1ns / 1ps
`include "integer_to_radix_text_padded_macros.svh"

module itrtp_dp #(
    parameter int VALUE_BITS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  itrtp_pkg::dp_cmd_t cmd,
    output itrtp_pkg::dp_sts_t sts,
    input  logic [63:0]        value,
    input  logic               is_signed,
    input  logic [4:0]         radix,
    input  logic               upper_case,
    input  logic [5:0]         field_width,
    input  logic [5:0]         min_digits,
    input  logic               left_justify,
    input  logic               zero_pad,
    input  logic               pointer_prefix,
    output logic               out_strobe,
    output logic [7:0]         out_char,
    output logic               last_char
);

    localparam int SLICE = itrtp_pkg::SLICE_BITS;
    localparam int CYC   = (VALUE_BITS + SLICE - 1) / SLICE;
    localparam int DIV_W = CYC * SLICE;
    localparam int SC_W  = (CYC > 1) ? $clog2(CYC) : 1;
    localparam int DEPTH = VALUE_BITS;
    localparam int DW    = $clog2(DEPTH + 1);
    localparam int CW    = itrtp_pkg::CNT_W;

    logic [DIV_W-1:0] dvd_reg;
    logic [3:0]       rem_reg;
    logic [SC_W-1:0]  slice_reg;
    logic [DW-1:0]    dcnt_reg;
    logic [3:0]       stk_reg [DEPTH];
    logic [4:0]       radix_reg;
    logic             upper_reg;
    logic [5:0]       width_reg;
    logic [5:0]       prec_reg;
    logic             left_reg;
    logic             zpad_reg;
    logic             ptr_reg;
    logic [CW-1:0]    b1_reg;
    logic [CW-1:0]    b2_reg;
    logic [CW-1:0]    b3_reg;
    logic [5:0]       lastk_reg;
    logic [5:0]       k_reg;
    logic             out_valid_reg;
    logic [7:0]       out_char_reg;
    logic             last_reg;

    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic [4:0]            radix_clamped;
    logic [DIV_W-1:0]      dvd_next;
    logic [3:0]            rem_next;
    logic [DIV_W-1:0]      dv;
    logic [3:0]            r;
    logic [4:0]            t;
    logic                  ge;
    logic                  slice_last;
    logic                  push;
    logic                  pop;

    logic [CW-1:0] d_ext;
    logic [CW-1:0] pfx;
    logic [CW-1:0] need;
    logic [CW-1:0] zeros;
    logic [CW-1:0] used;
    logic [CW-1:0] pads;
    logic [CW-1:0] b2_calc;
    logic [CW-1:0] b3_calc;
    logic [CW-1:0] total;
    logic [CW-1:0] k_ext;
    logic          is_digit;
    logic [7:0]    ch_next;
    logic          emit_last;

    assign raw = value[VALUE_BITS-1:0];
    assign mag = (is_signed && raw[VALUE_BITS-1])
               ? (~raw) + {{(VALUE_BITS-1){1'b0}}, 1'b1} : raw;

    always_comb
    begin
        priority if (radix < itrtp_pkg::RADIX_MIN)
        begin
            radix_clamped = itrtp_pkg::RADIX_MIN;
        end
        else if (radix > itrtp_pkg::RADIX_MAX)
        begin
            radix_clamped = itrtp_pkg::RADIX_MAX;
        end
        else
        begin
            radix_clamped = radix;
        end
    end

    always_comb
    begin
        dv = dvd_reg;
        r  = (slice_reg == '0) ? 4'd0 : rem_reg;
        t  = '0;
        ge = 1'b0;
        for (int i = 0; i < SLICE; i++)
        begin
            t  = {r, dv[DIV_W-1]};
            ge = (t >= radix_reg);
            r  = ge ? 4'(t - radix_reg) : t[3:0];
            dv = {dv[DIV_W-2:0], ge};
        end
        dvd_next = dv;
        rem_next = r;
    end

    assign slice_last = (slice_reg == SC_W'(CYC - 1));
    assign push       = cmd.step && slice_last;

    always_comb
    begin
        d_ext   = CW'(dcnt_reg);
        pfx     = ptr_reg ? CW'(2) : '0;
        need    = d_ext + pfx;
        zeros   = (CW'(prec_reg) > need) ? CW'(prec_reg) - need : '0;
        used    = need + zeros;
        pads    = (CW'(width_reg) > used) ? CW'(width_reg) - used : '0;
        b2_calc = zeros + (left_reg ? '0 : pads);
        b3_calc = b2_calc + pfx;
        total   = b3_calc + d_ext;
    end

    assign k_ext     = CW'(k_reg);
    assign is_digit  = (k_ext >= b3_reg);
    assign pop       = cmd.emit && is_digit;
    assign emit_last = (k_reg == lastk_reg);

    always_comb
    begin
        priority if (k_ext < b1_reg)
        begin
            ch_next = itrtp_pkg::CH_ZERO;
        end
        else if (k_ext < b2_reg)
        begin
            ch_next = zpad_reg ? itrtp_pkg::CH_ZERO : itrtp_pkg::CH_SPACE;
        end
        else if (k_ext < b3_reg)
        begin
            ch_next = (k_ext == b2_reg) ? itrtp_pkg::CH_ZERO : itrtp_pkg::CH_X;
        end
        else
        begin
            ch_next = itrtp_pkg::digit_char(stk_reg[0], upper_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg     <= '0;
            dcnt_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.emit;
            if (cmd.load)
            begin
                slice_reg <= '0;
                dcnt_reg  <= '0;
                k_reg     <= '0;
            end
            else
            begin
                if (cmd.step)
                begin
                    slice_reg <= slice_last ? '0 : slice_reg + 1'b1;
                end
                if (push)
                begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                else if (pop)
                begin
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
                if (cmd.emit)
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dvd_reg   <= DIV_W'(mag);
            radix_reg <= radix_clamped;
            upper_reg <= upper_case;
            width_reg <= field_width;
            prec_reg  <= min_digits;
            left_reg  <= left_justify;
            zpad_reg  <= zero_pad;
            ptr_reg   <= pointer_prefix && !is_signed;
        end
        else if (cmd.step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        if (push)
        begin
            stk_reg[0] <= rem_next;
            for (int i = 1; i < DEPTH; i++)
            begin
                stk_reg[i] <= stk_reg[i-1];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                stk_reg[i] <= stk_reg[i+1];
            end
        end
        if (cmd.calc)
        begin
            b1_reg    <= zeros;
            b2_reg    <= b2_calc;
            b3_reg    <= b3_calc;
            lastk_reg <= (total > CW'(itrtp_pkg::MAX_CHARS))
                       ? 6'(itrtp_pkg::MAX_CHARS - 1) : 6'(total - 1'b1);
        end
        if (cmd.emit)
        begin
            out_char_reg <= ch_next;
            last_reg     <= emit_last;
        end
    end

    assign sts.slice_last  = slice_last;
    assign sts.more_digits = (dvd_reg != '0) && (dcnt_reg < DW'(DEPTH));
    assign sts.emit_last   = emit_last;

    assign out_strobe = out_valid_reg;
    assign out_char   = out_char_reg;
    assign last_char  = last_reg;

    `ITRTP_ASSERT_NEXT(a_burst, out_valid_reg && !last_reg, out_valid_reg, "character burst broken before last")
    `ITRTP_ASSERT_NOW(a_pop_nonempty, pop, dcnt_reg != '0, "digit stack popped while empty")

endmodule

### design/integer_to_radix_text_padded.sv
// Top level of the padded radix integer formatter
//
//   channel | handshake          | word
//   --------+--------------------+-----------------------------------------------
//   in      | start && !busy     | value, is_signed, radix, upper_case,
//           |                    | field_width, min_digits, left_justify,
//           |                    | zero_pad, pointer_prefix
//   out     | out_strobe         | out_char, last_char
//
// Each digit is divided out of the value in slices of 8 bits and then checked for more digits;
// the N characters out of a word (at most 64) follow once all digits are on the stack.
// The divider retires 8 quotient bits per cycle; the characters then leave one per cycle.
// busy falls as the last character is registered; its strobe shows with busy low.
// Reset is asynchronous and returns the sequencer to idle with no strobe pending.
// The output cannot be stalled; each character is shown for exactly one cycle.
`timescale 1ns / 1ps

module integer_to_radix_text_padded #(
    parameter int VALUE_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] value,
    input  logic        is_signed,
    input  logic [4:0]  radix,
    input  logic        upper_case,
    input  logic [5:0]  field_width,
    input  logic [5:0]  min_digits,
    input  logic        left_justify,
    input  logic        zero_pad,
    input  logic        pointer_prefix,
    output logic        out_strobe,
    output logic [7:0]  out_char,
    output logic        last_char
);

    itrtp_pkg::dp_cmd_t cmd;
    itrtp_pkg::dp_sts_t sts;

    itrtp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    itrtp_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .value          (value),
        .is_signed      (is_signed),
        .radix          (radix),
        .upper_case     (upper_case),
        .field_width    (field_width),
        .min_digits     (min_digits),
        .left_justify   (left_justify),
        .zero_pad       (zero_pad),
        .pointer_prefix (pointer_prefix),
        .out_strobe     (out_strobe),
        .out_char       (out_char),
        .last_char      (last_char)
    );

endmodule

### test/testbench.sv
// Self-checking testbench for the padded radix integer formatter
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 700;

    typedef struct {
        logic [63:0] value;
        logic        is_signed;
        logic [4:0]  radix;
        logic        upper;
        logic [5:0]  width;
        logic [5:0]  prec;
        logic        left;
        logic        zpad;
        logic        pfx;
    } fmt_word_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] value = '0;
    logic        is_signed = 1'b0;
    logic [4:0]  radix = itrtp_pkg::RADIX_MIN;
    logic        upper_case = 1'b0;
    logic [5:0]  field_width = '0;
    logic [5:0]  min_digits = '0;
    logic        left_justify = 1'b0;
    logic        zero_pad = 1'b0;
    logic        pointer_prefix = 1'b0;
    logic        out_strobe;
    logic [7:0]  out_char;
    logic        last_char;

    text_char_t  expected_text[$];
    text_char_t  want_char;
    int          idle_pct = 0;
    int          errors = 0;
    int          words_taken = 0;
    int          chars_checked = 0;
    int          cycle_count = 0;

    integer_to_radix_text_padded dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .value(value),
        .is_signed(is_signed),
        .radix(radix),
        .upper_case(upper_case),
        .field_width(field_width),
        .min_digits(min_digits),
        .left_justify(left_justify),
        .zero_pad(zero_pad),
        .pointer_prefix(pointer_prefix),
        .out_strobe(out_strobe),
        .out_char(out_char),
        .last_char(last_char)
    );

    always #10 clk = ~clk;

    task automatic predict_text(input fmt_word_t w);
        logic [63:0] mag;
        logic [4:0]  base;
        logic [3:0]  digs[64];
        logic [7:0]  line[$];
        logic [7:0]  ch;
        logic        ptr;
        int          n_dig;
        int          n_zero;
        int          n_pad;
        int          n_out;
        int          i;
        base = w.radix;
        if (base < itrtp_pkg::RADIX_MIN)
        begin
            base = itrtp_pkg::RADIX_MIN;
        end
        if (base > itrtp_pkg::RADIX_MAX)
        begin
            base = itrtp_pkg::RADIX_MAX;
        end
        ptr = w.pfx && !w.is_signed;
        mag = w.value;
        if (w.is_signed && mag[63])
        begin
            mag = -mag;
        end
        n_dig = 0;
        do
        begin
            digs[n_dig] = 4'(mag % 64'(base));
            mag = mag / 64'(base);
            n_dig++;
        end
        while (mag != 0 && n_dig < 64);
        n_zero = int'(w.prec) - n_dig - (ptr ? 2 : 0);
        if (n_zero < 0)
        begin
            n_zero = 0;
        end
        n_pad = int'(w.width) - n_dig - (ptr ? 2 : 0) - n_zero;
        if (n_pad < 0)
        begin
            n_pad = 0;
        end
        for (i = 0; i < n_zero; i++)
        begin
            line.push_back(itrtp_pkg::CH_ZERO);
        end
        if (!w.left)
        begin
            for (i = 0; i < n_pad; i++)
            begin
                line.push_back(w.zpad ? itrtp_pkg::CH_ZERO : itrtp_pkg::CH_SPACE);
            end
        end
        if (ptr)
        begin
            line.push_back(itrtp_pkg::CH_ZERO);
            line.push_back(itrtp_pkg::CH_X);
        end
        for (i = n_dig - 1; i >= 0; i--)
        begin
            if (digs[i] < 4'd10)
            begin
                ch = itrtp_pkg::CH_ZERO + 8'(digs[i]);
            end
            else
            begin
                ch = (w.upper ? 8'h41 : 8'h61) + 8'(digs[i]) - 8'd10;
            end
            line.push_back(ch);
        end
        n_out = (line.size() > itrtp_pkg::MAX_CHARS) ? itrtp_pkg::MAX_CHARS : line.size();
        for (i = 0; i < n_out; i++)
        begin
            expected_text.push_back('{ch: line[i], last: (i == n_out - 1)});
        end
    endtask

    function automatic fmt_word_t fmt(input logic [63:0] v, input logic sgn,
                                      input logic [4:0] rdx, input logic up,
                                      input logic [5:0] w, input logic [5:0] p,
                                      input logic lj, input logic zp, input logic px);
        fmt_word_t f;
        f.value = v;
        f.is_signed = sgn;
        f.radix = rdx;
        f.upper = up;
        f.width = w;
        f.prec = p;
        f.left = lj;
        f.zpad = zp;
        f.pfx = px;
        return f;
    endfunction

    function automatic fmt_word_t random_word();
        fmt_word_t   f;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if ($urandom_range(1))
        begin
            raw = raw >> $urandom_range(63);
        end
        f.is_signed = 1'($urandom_range(1));
        if (f.is_signed && $urandom_range(1))
        begin
            raw = -raw;
        end
        f.value = raw;
        f.radix = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 2));
        f.upper = 1'($urandom_range(1));
        f.width = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(20));
        f.prec = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(20));
        f.left = 1'($urandom_range(1));
        f.zpad = 1'($urandom_range(1));
        f.pfx = 1'($urandom_range(1));
        return f;
    endfunction

    task automatic send_word(input fmt_word_t f);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        value <= f.value;
        is_signed <= f.is_signed;
        radix <= f.radix;
        upper_case <= f.upper;
        field_width <= f.width;
        min_digits <= f.prec;
        left_justify <= f.left;
        zero_pad <= f.zpad;
        pointer_prefix <= f.pfx;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic test_digits();
        send_word(fmt(64'd0, 1'b0, 5'd10, 1'b0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_word(fmt('1, 1'b0, 5'd2, 1'b0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_word(fmt('1, 1'b0, 5'd16, 1'b1, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_word(fmt(64'hfedcba9876543210, 1'b0, 5'd16, 1'b0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_word(fmt(64'h0123456789abcdef, 1'b0, 5'd16, 1'b1, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_word(fmt(64'h8000000000000000, 1'b1, 5'd10, 1'b0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_word(fmt('1, 1'b1, 5'd10, 1'b0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_word(fmt(64'h7fffffffffffffff, 1'b1, 5'd8, 1'b0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_word(fmt('1, 1'b0, 5'd3, 1'b0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_radix_clamp();
        send_word(fmt(64'd255, 1'b0, 5'd0, 1'b0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_word(fmt(64'd255, 1'b0, 5'd1, 1'b0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_word(fmt(64'd255, 1'b0, 5'd17, 1'b1, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_word(fmt(64'd255, 1'b0, 5'd31, 1'b0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_padding();
        send_word(fmt(64'd42, 1'b0, 5'd10, 1'b0, 6'd62, 6'd0, 1'b0, 1'b0, 1'b0));
        send_word(fmt(64'd42, 1'b0, 5'd10, 1'b0, 6'd63, 6'd0, 1'b0, 1'b1, 1'b0));
        send_word(fmt(64'd42, 1'b0, 5'd10, 1'b0, 6'd40, 6'd0, 1'b1, 1'b0, 1'b0));
        send_word(fmt(64'd42, 1'b0, 5'd10, 1'b0, 6'd0, 6'd62, 1'b0, 1'b0, 1'b0));
        send_word(fmt(64'd42, 1'b0, 5'd10, 1'b0, 6'd10, 6'd20, 1'b0, 1'b1, 1'b0));
        send_word(fmt(64'd1234, 1'b0, 5'd10, 1'b0, 6'd20, 6'd8, 1'b0, 1'b0, 1'b0));
        send_word(fmt(64'd123456, 1'b0, 5'd10, 1'b0, 6'd3, 6'd2, 1'b0, 1'b1, 1'b0));
    endtask

    task automatic test_pointer();
        send_word(fmt(64'hbeef, 1'b0, 5'd16, 1'b0, 6'd20, 6'd0, 1'b0, 1'b1, 1'b1));
        send_word(fmt(64'hbeef, 1'b0, 5'd16, 1'b1, 6'd0, 6'd10, 1'b0, 1'b0, 1'b1));
        send_word(fmt(64'hbeef, 1'b1, 5'd16, 1'b0, 6'd20, 6'd0, 1'b0, 1'b0, 1'b1));
        send_word(fmt('1, 1'b0, 5'd2, 1'b0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b1));
        send_word(fmt(64'd0, 1'b0, 5'd2, 1'b0, 6'd63, 6'd0, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_random(input int count, input int pct);
        idle_pct = pct;
        repeat (count)
        begin
            send_word(random_word());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            predict_text(fmt(value, is_signed, radix, upper_case, field_width, min_digits,
                             left_justify, zero_pad, pointer_prefix));
            words_taken++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_strobe)
        begin
            if (expected_text.size() == 0)
            begin
                $error("unexpected character out_char=%h last_char=%b", out_char, last_char);
                errors++;
            end
            else
            begin
                want_char = expected_text.pop_front();
                chars_checked++;
                if (out_char !== want_char.ch)
                begin
                    $error("out_char expected %h actual %h", want_char.ch, out_char);
                    errors++;
                end
                if (last_char !== want_char.last)
                begin
                    $error("last_char expected %b actual %b", want_char.last, last_char);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_digits();
        test_radix_clamp();
        test_padding();
        test_pointer();
        test_random(70, 0);
        test_random(70, 77);
        test_random(60, 14);
        start <= 1'b0;
        @(posedge clk);
        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_text.size() != 0)
        begin
            $error("%0d characters never arrived", expected_text.size());
            errors++;
        end
        $display("covered %0d words and %0d characters: digits in every radix, radix clamp,",
                 words_taken, chars_checked);
        $display("width and precision padding, pointer prefix and truncation at 64 characters");
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/itrtp_pkg.sv
design/itrtp_ctrl.sv
design/itrtp_dp.sv
design/integer_to_radix_text_padded.sv
test/testbench.sv
